@@ rtl/record_line_tokenizer_defines.svh @@
// ---------------------------------------------------------------------------
// Record line tokenizer assertion macros
// Concurrent assertion helpers shared by the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef RECORD_LINE_TOKENIZER_DEFINES_SVH
`define RECORD_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define RLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("record_line_tokenizer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("record_line_tokenizer: assertion failed");

`else

`define RLT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/rlt_pkg.sv @@
// ---------------------------------------------------------------------------
// Record line tokenizer package
// Word types of both channels and the token kind codes.
// ---------------------------------------------------------------------------
package rlt_pkg;

	// Token kind codes as they appear on the output word.
	localparam logic [2:0] KIND_INT = 3'd0;
	localparam logic [2:0] KIND_STR = 3'd1;
	localparam logic [2:0] KIND_BIN = 3'd2;
	localparam logic [2:0] KIND_EOL = 3'd3;
	localparam logic [2:0] KIND_ERR = 3'd4;

	// One byte of the text buffer.
	typedef struct packed {
		logic [7:0] char_code;
		logic       buffer_end;
	} byte_word_t;

	// One token.
	typedef struct packed {
		logic [2:0]  token_kind;
		logic [31:0] token_value;
		logic [15:0] start_offset;
		logic [15:0] end_offset;
		logic        last_of_run;
	} token_word_t;

endpackage

@@ rtl/record_line_tokenizer.sv @@
// ---------------------------------------------------------------------------
// Record line tokenizer
// Splits a byte stream into integer, string, hex blob, end of line and error
// tokens, each with start and end offsets into the buffer.
// ---------------------------------------------------------------------------
// One byte is taken per clock cycle unless the input stalls. A byte is held
// in an input register, where the scanner state is updated and the zero, one
// or two tokens it causes are pushed into a four-word result queue; the input
// stalls only when that queue has fewer than two free words. The queue drains
// one token per cycle unless the receiver stalls, so the sustained rate is
// one byte per cycle while the stream averages at most one token per byte.
// Offsets saturate at 2^OFFSET_WIDTH - 1 and are shown in 16 bits; integer
// values wrap to VALUE_WIDTH bits and are shown in 32. After an error, bytes
// are discarded up to the next end of line.
// ---------------------------------------------------------------------------
`include "record_line_tokenizer_defines.svh"

module record_line_tokenizer #(
	parameter int OFFSET_WIDTH = 16,
	parameter int VALUE_WIDTH  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  rlt_pkg::byte_word_t byte_data,
	output logic                token_valid,
	input  logic                token_stall,
	output rlt_pkg::token_word_t token_data
);

	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};
	localparam int QDEPTH = 4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	typedef enum logic [6:0] {
		M_IDLE = 7'b0000001,
		M_STR  = 7'b0000010,
		M_BLOB = 7'b0000100,
		M_ZERO = 7'b0001000,
		M_DEC  = 7'b0010000,
		M_HEX  = 7'b0100000,
		M_SKIP = 7'b1000000
	} mode_t;

	// Kind given when a blob or number closes.
	function automatic logic [2:0] close_kind(input mode_t m, input logic parity);
		logic [2:0] k;
		k = rlt_pkg::KIND_INT;
		if (m == M_BLOB) begin
			k = parity ? rlt_pkg::KIND_ERR : rlt_pkg::KIND_BIN;
		end
		return k;
	endfunction

	function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] p);
		return (p == OFFSET_MAX) ? p : p + 1'b1;
	endfunction

	// Input register.
	logic [7:0] char_s1;
	logic       end_s1;
	logic       valid_s1;

	// Scanner state.
	mode_t                   mode_q;
	logic [VALUE_WIDTH-1:0]  acc_q;
	logic [OFFSET_WIDTH-1:0] tstart_q;
	logic [OFFSET_WIDTH-1:0] pos_q;

	// Result queue.
	rlt_pkg::token_word_t queue_q [QDEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	logic fire;
	logic pop;
	logic [1:0] push_n;

	assign fire       = valid_s1 && (count_q <= 3'(QDEPTH - 2));
	assign byte_stall = valid_s1 && !fire;
	assign token_valid = (count_q != 3'd0);
	assign token_data  = queue_q[rd_ptr_q];
	assign pop         = token_valid && !token_stall;

	// Character classes of the byte in the input register.
	logic       is_term;
	logic       is_dec;
	logic       is_hex;
	logic [3:0] dig_val;

	always_comb begin
		is_term = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB) ||
			(char_s1 == CH_CR) || (char_s1 == CH_LF);
		is_dec  = char_s1 inside {[8'h30:8'h39]};
		is_hex  = is_dec || (char_s1 inside {[8'h41:8'h46], [8'h61:8'h66]});
		dig_val = is_dec ? char_s1[3:0] : 4'(char_s1[3:0] + 4'd9);
	end

	// Scanner step: state update and the tokens that the byte causes.
	mode_t                   mode_m;
	mode_t                   mode_d;
	logic [VALUE_WIDTH-1:0]  acc_m;
	logic [OFFSET_WIDTH-1:0] ts_m;
	logic [OFFSET_WIDTH-1:0] pos_inc;
	logic [OFFSET_WIDTH-1:0] pos_d;
	logic                    a_vld;
	logic [2:0]              a_kind;
	logic [OFFSET_WIDTH-1:0] a_s;
	logic [OFFSET_WIDTH-1:0] a_e;
	logic                    b_vld;
	logic [2:0]              b_kind;
	logic                    eol_vld;
	logic [OFFSET_WIDTH-1:0] eol_off;
	logic                    is_lf;
	rlt_pkg::token_word_t    tok0;
	rlt_pkg::token_word_t    tok1;

	always_comb begin
		pos_inc = sat_inc(pos_q);
		is_lf   = (char_s1 == CH_LF);
		mode_m  = mode_q;
		acc_m   = acc_q;
		ts_m    = tstart_q;
		a_vld   = 1'b0;
		a_kind  = rlt_pkg::KIND_ERR;
		a_s     = tstart_q;
		a_e     = pos_q;

		case (mode_q)
			M_IDLE: begin
				if (!is_term) begin
					ts_m  = pos_q;
					acc_m = '0;
					if (char_s1 == CH_QUOTE) begin
						mode_m = M_STR;
						ts_m   = pos_inc;
					end else if (char_s1 == CH_DOLLAR) begin
						mode_m = M_BLOB;
						ts_m   = pos_inc;
					end else if (char_s1 == CH_ZERO) begin
						mode_m = M_ZERO;
					end else if (is_dec) begin
						mode_m = M_DEC;
						acc_m  = VALUE_WIDTH'(char_s1[3:0]);
					end else begin
						mode_m = M_SKIP;
						a_vld  = 1'b1;
						a_s    = pos_q;
					end
				end
			end
			M_STR: begin
				if (char_s1 == CH_QUOTE) begin
					a_vld  = 1'b1;
					a_kind = rlt_pkg::KIND_STR;
					mode_m = M_IDLE;
				end else if (char_s1 == CH_LF || char_s1 == CH_CR) begin
					a_vld  = 1'b1;
					mode_m = M_SKIP;
				end
			end
			M_BLOB, M_ZERO, M_DEC, M_HEX: begin
				if (mode_q == M_ZERO && (char_s1 == CH_X_UP || char_s1 == CH_X_LO)) begin
					// A hex prefix on the final byte can never take a digit.
					if (end_s1) begin
						a_vld  = 1'b1;
						mode_m = M_SKIP;
					end else begin
						mode_m = M_HEX;
					end
				end else if (is_term) begin
					a_vld  = 1'b1;
					a_kind = close_kind(mode_q, acc_q[0]);
					mode_m = (a_kind == rlt_pkg::KIND_ERR) ? M_SKIP : M_IDLE;
				end else if (mode_q == M_BLOB && is_hex) begin
					acc_m = {acc_q[VALUE_WIDTH-1:1], ~acc_q[0]};
				end else if (mode_q == M_ZERO && is_dec) begin
					mode_m = M_DEC;
					acc_m  = VALUE_WIDTH'(char_s1[3:0]);
				end else if (mode_q == M_DEC && is_dec) begin
					acc_m = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(char_s1[3:0]);
				end else if (mode_q == M_HEX && is_hex) begin
					acc_m = (acc_q << 4) | VALUE_WIDTH'(dig_val);
				end else begin
					a_vld  = 1'b1;
					mode_m = M_SKIP;
				end
			end
			M_SKIP: begin
				mode_m = M_SKIP;
			end
			default: begin
				mode_m = M_SKIP;
			end
		endcase

		// Newline or buffer end: close what is open, then end of line.
		b_vld   = 1'b0;
		b_kind  = rlt_pkg::KIND_ERR;
		eol_vld = is_lf || end_s1;
		eol_off = is_lf ? pos_q : pos_inc;
		if (!is_lf && end_s1) begin
			if (mode_m == M_STR) begin
				b_vld = 1'b1;
			end else if (mode_m == M_BLOB || mode_m == M_ZERO ||
				mode_m == M_DEC || mode_m == M_HEX) begin
				b_vld  = 1'b1;
				b_kind = close_kind(mode_m, acc_m[0]);
			end
		end
		mode_d = eol_vld ? M_IDLE : mode_m;
		pos_d  = end_s1 ? '0 : pos_inc;

		// First queue word: the token from the scan, else the closing token.
		tok0.token_kind   = a_vld ? a_kind : b_kind;
		tok0.token_value  = '0;
		if ((a_vld ? a_kind : b_kind) == rlt_pkg::KIND_INT) begin
			tok0.token_value = 32'(acc_m);
		end
		tok0.start_offset = 16'(a_vld ? a_s : ts_m);
		tok0.end_offset   = 16'(a_vld ? a_e : eol_off);
		tok0.last_of_run  = !eol_vld;

		tok1.token_kind   = rlt_pkg::KIND_EOL;
		tok1.token_value  = '0;
		tok1.start_offset = 16'(eol_off);
		tok1.end_offset   = 16'(eol_off);
		tok1.last_of_run  = 1'b1;

		push_n = 2'(a_vld || b_vld) + 2'(eol_vld);
	end

	// Input register and scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			acc_q    <= '0;
			tstart_q <= '0;
			pos_q    <= '0;
		end else begin
			if (byte_valid && !byte_stall) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				mode_q   <= mode_d;
				acc_q    <= acc_m;
				tstart_q <= ts_m;
				pos_q    <= pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			char_s1 <= byte_data.char_code;
			end_s1  <= byte_data.buffer_end;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + push_n;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (fire ? 3'(push_n) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	// Result queue storage: the first word goes to the write pointer.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (a_vld || b_vld) begin
				queue_q[wr_ptr_q]        <= tok0;
				queue_q[wr_ptr_q + 2'd1] <= tok1;
			end else begin
				queue_q[wr_ptr_q]        <= tok1;
			end
		end
	end

	// The queue never holds more words than it has.
	`RLT_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, count_q <= 3'(QDEPTH))
	// Every buffer end yields at least its end of line token.
	`RLT_ASSERT_NOW(a_end_gives_eol, clk, arst_n, fire && end_s1, push_n != 2'd0)
	// A newline always leaves the scanner between tokens.
	`RLT_ASSERT_NEXT(a_lf_idle, clk, arst_n, fire && char_s1 == CH_LF, mode_q == M_IDLE)
	// The offset counter restarts after the final byte of a buffer.
	`RLT_ASSERT_NEXT(a_end_pos, clk, arst_n, fire && end_s1, pos_q == '0)

endmodule

@@ verif/tb_record_line_tokenizer.sv @@
// ---------------------------------------------------------------------------
// Record line tokenizer testbench
// Sends byte words through the input channel and checks every token word
// against a predictor of the scanner, which runs in this module. The tests
// are directed token kinds, error recovery, buffer end handling and value
// wrap, followed by random records. The sender idles and the receiver stalls
// at random throughout.
// ---------------------------------------------------------------------------
module tb_record_line_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT  = 100000;
	localparam int ITEM_COUNT = 1150;
	localparam int SETTLE     = 20;
	localparam int REPORT_MAX = 10;

	localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_STR,
		SCAN_BLOB,
		SCAN_ZERO,
		SCAN_DEC,
		SCAN_HEX,
		SCAN_SKIP
	} scan_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	rlt_pkg::byte_word_t  byte_data;
	logic                 token_valid;
	logic                 token_stall;
	rlt_pkg::token_word_t token_data;

	// Scanner state as predicted from the accepted byte words.
	scan_mode_t  sc_mode;
	logic [31:0] sc_acc;
	logic [15:0] sc_start;
	logic [15:0] sc_pos;

	rlt_pkg::token_word_t pending_tokens[$];

	int cycle_count;
	int mismatch_count;
	int tokens_checked;
	int error_tokens_seen;
	int bytes_sent;
	int buffers_sent;
	int burst_left;

	record_line_tokenizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [15:0] next_offset(logic [15:0] p);
		return (p == OFFSET_MAX) ? p : p + 16'd1;
	endfunction

	function automatic int hex_value(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c - CH_0);
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return int'(c - CH_UPPER_A) + 10;
		if (c >= CH_LOWER_A && c <= CH_LOWER_F)
			return int'(c - CH_LOWER_A) + 10;
		return -1;
	endfunction

	function automatic void add_token(logic [2:0] kind, logic [31:0] val,
			logic [15:0] s, logic [15:0] e);
		rlt_pkg::token_word_t t;
		t.token_kind   = kind;
		t.token_value  = val;
		t.start_offset = s;
		t.end_offset   = e;
		t.last_of_run  = 1'b0;
		pending_tokens.push_back(t);
	endfunction

	function automatic void raise_error(logic [15:0] s, logic [15:0] e);
		sc_mode = SCAN_SKIP;
		add_token(rlt_pkg::KIND_ERR, 32'd0, s, e);
	endfunction

	// Closes an open number or blob; a blob with an odd digit count fails.
	function automatic void close_open_token(logic [15:0] e);
		if (sc_mode == SCAN_BLOB && sc_acc[0]) begin
			raise_error(sc_start, e);
		end else if (sc_mode == SCAN_BLOB) begin
			add_token(rlt_pkg::KIND_BIN, 32'd0, sc_start, e);
			sc_mode = SCAN_IDLE;
		end else begin
			add_token(rlt_pkg::KIND_INT, sc_acc, sc_start, e);
			sc_mode = SCAN_IDLE;
		end
	endfunction

	// Works out the tokens caused by one accepted byte word.
	function automatic void scan_byte(rlt_pkg::byte_word_t w);
		logic [7:0]  c;
		logic        fin;
		logic [15:0] p;
		logic [15:0] e;
		logic        is_term;
		logic        is_dec;
		int          d;
		int          base;
		c       = w.char_code;
		fin     = w.buffer_end;
		p       = sc_pos;
		is_term = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
		is_dec  = (c >= CH_0) && (c <= CH_9);
		d       = hex_value(c);
		base    = pending_tokens.size();

		case (sc_mode)
			SCAN_IDLE: begin
				if (!is_term) begin
					sc_start = p;
					sc_acc   = 32'd0;
					if (c == CH_QUOTE) begin
						sc_mode  = SCAN_STR;
						sc_start = next_offset(p);
					end else if (c == CH_DOLLAR) begin
						sc_mode  = SCAN_BLOB;
						sc_start = next_offset(p);
					end else if (c == CH_0) begin
						sc_mode = SCAN_ZERO;
					end else if (is_dec) begin
						sc_mode = SCAN_DEC;
						sc_acc  = {28'd0, c[3:0]};
					end else begin
						raise_error(p, p);
					end
				end
			end
			SCAN_STR: begin
				if (c == CH_QUOTE) begin
					add_token(rlt_pkg::KIND_STR, 32'd0, sc_start, p);
					sc_mode = SCAN_IDLE;
				end else if (c == CH_NL || c == CH_CR) begin
					raise_error(sc_start, p);
				end
			end
			SCAN_BLOB: begin
				if (is_term)
					close_open_token(p);
				else if (d >= 0)
					sc_acc[0] = ~sc_acc[0];
				else
					raise_error(sc_start, p);
			end
			SCAN_ZERO: begin
				if (c == CH_LOWER_X || c == CH_UPPER_X) begin
					if (fin)
						raise_error(sc_start, p);
					else
						sc_mode = SCAN_HEX;
				end else if (is_dec) begin
					sc_mode = SCAN_DEC;
					sc_acc  = {28'd0, c[3:0]};
				end else if (is_term) begin
					close_open_token(p);
				end else begin
					raise_error(sc_start, p);
				end
			end
			SCAN_DEC: begin
				if (is_dec)
					sc_acc = sc_acc * 32'd10 + {28'd0, c[3:0]};
				else if (is_term)
					close_open_token(p);
				else
					raise_error(sc_start, p);
			end
			SCAN_HEX: begin
				if (d >= 0)
					sc_acc = {sc_acc[27:0], 4'(d)};
				else if (is_term)
					close_open_token(p);
				else
					raise_error(sc_start, p);
			end
			default: ;
		endcase

		// A newline or the end of the buffer closes the line.
		if (c == CH_NL) begin
			add_token(rlt_pkg::KIND_EOL, 32'd0, p, p);
			sc_mode = SCAN_IDLE;
		end else if (fin) begin
			e = next_offset(p);
			if (sc_mode == SCAN_STR)
				raise_error(sc_start, e);
			else if (sc_mode == SCAN_BLOB || sc_mode == SCAN_ZERO ||
					sc_mode == SCAN_DEC || sc_mode == SCAN_HEX)
				close_open_token(e);
			add_token(rlt_pkg::KIND_EOL, 32'd0, e, e);
			sc_mode = SCAN_IDLE;
		end

		sc_pos = fin ? 16'd0 : next_offset(p);
		if (pending_tokens.size() > base)
			pending_tokens[pending_tokens.size() - 1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Token word checking and receiver stalls
	// ------------------------------------------------------------------

	function automatic string token_text(rlt_pkg::token_word_t t);
		return $sformatf("kind %0d value %h start %h end %h last %b", t.token_kind,
			t.token_value, t.start_offset, t.end_offset, t.last_of_run);
	endfunction

	function automatic void check_token(rlt_pkg::token_word_t got);
		rlt_pkg::token_word_t want;
		tokens_checked++;
		if (got.token_kind == rlt_pkg::KIND_ERR)
			error_tokens_seen++;
		if (pending_tokens.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("[%0t] unexpected token: %s", $realtime, token_text(got));
			return;
		end
		want = pending_tokens.pop_front();
		if (got.token_kind !== want.token_kind || got.token_value !== want.token_value ||
				got.start_offset !== want.start_offset ||
				got.end_offset !== want.end_offset ||
				got.last_of_run !== want.last_of_run) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("[%0t] token mismatch: expected %s, got %s", $realtime,
					token_text(want), token_text(got));
		end
	endfunction

	// The receiver switches at random between stall patterns.
	always @(posedge clk) begin
		static int stall_mode = 0;
		static int mode_left  = 0;
		logic      stall_next;
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("[%0t] run limit reached with %0d tokens outstanding", $realtime,
				pending_tokens.size());
			$display("tb_record_line_tokenizer: done, errors");
			$finish;
		end else begin
			if (arst_n && token_valid && !token_stall)
				check_token(token_data);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       stall_next = 1'b0;
				1:       stall_next = ($urandom_range(0, 3) == 0);
				2:       stall_next = ($urandom_range(0, 9) < 7);
				default: stall_next = ((cycle_count % 5) < 2);
			endcase
			token_stall <= stall_next;
		end
	end

	// ------------------------------------------------------------------
	// Sending
	// ------------------------------------------------------------------

	// Sends one byte word in bursts with random gaps and predicts its tokens.
	task automatic send_byte(logic [7:0] c, logic fin);
		rlt_pkg::byte_word_t w;
		int                  gap;
		w.char_code  = c;
		w.buffer_end = fin;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_data  <= w;
		do @(posedge clk); while (byte_stall);
		scan_byte(w);
		bytes_sent++;
		if (fin)
			buffers_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_text(string s, logic end_buf);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], end_buf && (i == s.len() - 1));
	endtask

	// Holds the sender off until every predicted token has come back.
	task automatic drain_tokens();
		byte_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_token_kinds();
		send_text("12 0x1F\t\"ab\" $0a1B\r\"\" $ 0\n", 1'b0);
		drain_tokens();
	endtask

	// Every error is followed by discarded bytes up to the end of the line.
	task automatic test_error_recovery();
		send_text("?7 \"x\n", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("1\n", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("\n\"a\rb\n$abc 5\n12z 3\n0q\n0xg\n\"x\n", 1'b0);
		drain_tokens();
	endtask

	task automatic test_buffer_end();
		send_text("0x", 1'b1);
		send_text("0x \"ab", 1'b1);
		send_text("99", 1'b1);
		send_text("$12", 1'b1);
		send_text("$1", 1'b1);
		send_text("0", 1'b1);
		send_text("0x1", 1'b1);
		send_text("\n", 1'b1);
		send_text(" ", 1'b1);
		send_text("?", 1'b1);
		drain_tokens();
	endtask

	task automatic test_value_wrap();
		send_text("4294967295 4294967296 0xFFFFFFFF 0X123456789 0XaBcDeF 09 ", 1'b0);
		send_text("99999999999\n", 1'b0);
		drain_tokens();
	endtask

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 8'(CH_0 + v);
		if (v < 16)
			return 8'(CH_UPPER_A + v - 10);
		return 8'(CH_LOWER_A + v - 16);
	endfunction

	// Builds one line: mostly well-formed tokens, sometimes corrupted or noise.
	task automatic send_random_record();
		logic [7:0] line_bytes[$];
		logic [7:0] ch;
		logic       end_buf;
		int         n_tok;
		int         len;
		if ($urandom_range(0, 19) == 0) begin
			len = $urandom_range(1, 12);
			repeat (len) line_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			n_tok = $urandom_range(1, 5);
			for (int k = 0; k < n_tok; k++) begin
				if (k > 0 || $urandom_range(0, 1) == 1)
					repeat ($urandom_range(1, 3)) line_bytes.push_back(random_blank());
				case ($urandom_range(0, 3))
					0: begin
						line_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
						repeat ($urandom_range(0, 11))
							line_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
					end
					1: begin
						line_bytes.push_back(CH_0);
						line_bytes.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
						repeat ($urandom_range(1, 10)) line_bytes.push_back(random_hex_char());
					end
					2: begin
						line_bytes.push_back(CH_QUOTE);
						repeat ($urandom_range(0, 8)) begin
							ch = 8'($urandom_range(32, 126));
							line_bytes.push_back((ch == CH_QUOTE) ? CH_LOWER_A : ch);
						end
						line_bytes.push_back(CH_QUOTE);
					end
					default: begin
						line_bytes.push_back(CH_DOLLAR);
						len = 2 * $urandom_range(0, 4) + ($urandom_range(0, 7) == 0);
						repeat (len) line_bytes.push_back(random_hex_char());
					end
				endcase
				if ($urandom_range(0, 9) == 0)
					line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
						8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 1) == 1)
				line_bytes.push_back(random_blank());
		end
		end_buf = ($urandom_range(0, 4) == 0);
		if (!end_buf || $urandom_range(0, 2) == 0)
			line_bytes.push_back(CH_NL);
		foreach (line_bytes[j])
			send_byte(line_bytes[j], end_buf && (j == line_bytes.size() - 1));
	endtask

	// Random records fill the run up to the planned number of byte words.
	task automatic test_random_records();
		int records;
		records = 0;
		while (bytes_sent < ITEM_COUNT) begin
			send_random_record();
			records++;
			if (records % 37 == 0)
				drain_tokens();
		end
		drain_tokens();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      <= 1'b0;
		byte_valid  <= 1'b0;
		byte_data   <= '0;
		token_stall <= 1'b0;
		sc_mode     = SCAN_IDLE;
		sc_acc      = 32'd0;
		sc_start    = 16'd0;
		sc_pos      = 16'd0;
		cycle_count       = 0;
		mismatch_count    = 0;
		tokens_checked    = 0;
		error_tokens_seen = 0;
		bytes_sent        = 0;
		buffers_sent      = 0;
		burst_left        = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_token_kinds();
		test_error_recovery();
		test_buffer_end();
		test_value_wrap();
		test_random_records();

		repeat (SETTLE) @(posedge clk);
		if (pending_tokens.size() != 0) begin
			mismatch_count++;
			$display("%0d expected tokens never arrived", pending_tokens.size());
		end
		$display("Sent %0d bytes in %0d buffers; checked %0d tokens, %0d of them errors.",
			bytes_sent, buffers_sent, tokens_checked, error_tokens_seen);
		$display("Mismatches: %0d.", mismatch_count);
		if (mismatch_count == 0)
			$display("tb_record_line_tokenizer: done, clean");
		else
			$display("tb_record_line_tokenizer: done, errors");
		$finish;
	end

endmodule
